FILE: hw/rtl/keyboard_scancode_decoder_macros.svh
// Assertion helpers shared by the RTL.
`ifndef KEYBOARD_SCANCODE_DECODER_MACROS_SVH
`define KEYBOARD_SCANCODE_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ksd_pkg.sv
`default_nettype none

package ksd_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    // Configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int LED_W  = 3;
    localparam logic [ADDR_W-3:0] REG_INITIAL_LEDS = '0;

    // Lock bit positions
    localparam int LOCK_CAPS_BIT = 2;

    // Keyboard bytes
    localparam logic [7:0] LED_CMD         = 8'hED;
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS         = 8'h3A;
    localparam logic [7:0] SC_NUM          = 8'h45;
    localparam logic [7:0] SC_SCROLL       = 8'h46;
    localparam logic [7:0] KB_ACK          = 8'hFA;
    localparam logic [7:0] KB_RESEND       = 8'hFE;
    localparam logic [7:0] NO_BYTE         = 8'hFF;

    localparam logic [LED_W-1:0] MASK_CAPS   = 3'b100;
    localparam logic [LED_W-1:0] MASK_NUM    = 3'b010;
    localparam logic [LED_W-1:0] MASK_SCROLL = 3'b001;

    localparam logic [7:0] LETTER_A    = 8'h41;
    localparam logic [7:0] LETTER_Z    = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } res_t;

    // Queue request from the decode stage
    typedef struct packed {
        logic             step;
        logic             push_pair;
        logic             pop;
        logic [LED_W-1:0] leds;
    } q_req_t;

    typedef struct packed {
        logic       ready;
        logic       empty;
        logic [7:0] pop_byte;
    } q_status_t;

    typedef enum logic [1:0] {
        FILL_DONE,
        FILL_LEDS,
        FILL_CMD
    } fill_state_t;

    function automatic logic [7:0] plain_map(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'h02: ch = 8'h31;
            7'h03: ch = 8'h32;
            7'h04: ch = 8'h33;
            7'h05: ch = 8'h34;
            7'h06: ch = 8'h35;
            7'h07: ch = 8'h36;
            7'h08: ch = 8'h37;
            7'h09: ch = 8'h38;
            7'h0A: ch = 8'h39;
            7'h0B: ch = 8'h30;
            7'h0C: ch = 8'h2D;
            7'h0D: ch = 8'h5E;
            7'h0E: ch = 8'h08;
            7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;
            7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;
            7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;
            7'h17: ch = 8'h49;
            7'h18: ch = 8'h4F;
            7'h19: ch = 8'h50;
            7'h1A: ch = 8'h40;
            7'h1B: ch = 8'h5B;
            7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h41;
            7'h1F: ch = 8'h53;
            7'h20: ch = 8'h44;
            7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;
            7'h24: ch = 8'h4A;
            7'h25: ch = 8'h4B;
            7'h26: ch = 8'h4C;
            7'h27: ch = 8'h3B;
            7'h28: ch = 8'h3A;
            7'h2B: ch = 8'h5D;
            7'h2C: ch = 8'h5A;
            7'h2D: ch = 8'h58;
            7'h2E: ch = 8'h43;
            7'h2F: ch = 8'h56;
            7'h30: ch = 8'h42;
            7'h31: ch = 8'h4E;
            7'h32: ch = 8'h4D;
            7'h33: ch = 8'h2C;
            7'h34: ch = 8'h2E;
            7'h35: ch = 8'h2F;
            7'h37: ch = 8'h2A;
            7'h39: ch = 8'h20;
            7'h47: ch = 8'h37;
            7'h48: ch = 8'h38;
            7'h49: ch = 8'h39;
            7'h4A: ch = 8'h2D;
            7'h4B: ch = 8'h34;
            7'h4C: ch = 8'h35;
            7'h4D: ch = 8'h36;
            7'h4E: ch = 8'h2B;
            7'h4F: ch = 8'h31;
            7'h50: ch = 8'h32;
            7'h51: ch = 8'h33;
            7'h52: ch = 8'h30;
            7'h53: ch = 8'h2E;
            7'h73: ch = 8'h5C;
            7'h7D: ch = 8'h5C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted layout: only the differing keys, the rest as plain
    function automatic logic [7:0] shifted_map(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'h02: ch = 8'h21;
            7'h03: ch = 8'h22;
            7'h04: ch = 8'h23;
            7'h05: ch = 8'h24;
            7'h06: ch = 8'h25;
            7'h07: ch = 8'h26;
            7'h08: ch = 8'h27;
            7'h09: ch = 8'h28;
            7'h0A: ch = 8'h29;
            7'h0B: ch = 8'h7E;
            7'h0C: ch = 8'h3D;
            7'h0D: ch = 8'h7E;
            7'h1A: ch = 8'h60;
            7'h1B: ch = 8'h7B;
            7'h27: ch = 8'h2B;
            7'h28: ch = 8'h2A;
            7'h2B: ch = 8'h7D;
            7'h33: ch = 8'h3C;
            7'h34: ch = 8'h3E;
            7'h35: ch = 8'h3F;
            7'h73: ch = 8'h5F;
            7'h7D: ch = 8'h7C;
            default: ch = plain_map(code);
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ksd_ram.sv
`default_nettype none

module ksd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ksd_cmd_queue.sv
`default_nettype none

module ksd_cmd_queue #(
    parameter int DEPTH = ksd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          restart,
    input  wire logic [ksd_pkg::LED_W-1:0]     restart_leds,
    input  wire ksd_pkg::q_req_t               req,
    output ksd_pkg::q_status_t                 status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    ksd_pkg::fill_state_t fill_reg, fill_next;

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic          pend_reg;
    logic [AW-1:0] pend_addr_reg;
    logic [7:0]    pend_data_reg;
    logic          settle_reg;

    logic [SW-1:0] tail_sum, tail1_sum;
    logic [AW-1:0] tail, tail1;
    logic [AW:0]   head_inc;
    logic [AW-1:0] head_adv;
    logic          ed_ok, l_ok;
    logic [CW-1:0] n_push;
    logic [CW-1:0] count_next;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rdata;
    logic          fill_we;
    logic [AW-1:0] fill_addr;
    logic [7:0]    fill_data;
    logic          push_ed;

    // Tail and tail+1, wrapped into the ring
    always_comb
    begin
        tail_sum  = SW'(head_reg) + SW'(count_reg);
        tail1_sum = tail_sum + SW'(1);
        if (tail_sum >= SW'(DEPTH))
        begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
        if (tail1_sum >= SW'(DEPTH))
        begin
            tail1_sum = tail1_sum - SW'(DEPTH);
        end
        tail  = tail_sum[AW-1:0];
        tail1 = tail1_sum[AW-1:0];
    end

    always_comb
    begin
        head_inc = {1'b0, head_reg} + (AW+1)'(1);
        if (head_inc == (AW+1)'(DEPTH))
        begin
            head_adv = '0;
        end
        else
        begin
            head_adv = head_inc[AW-1:0];
        end
    end

    // A full queue drops bytes; one free slot keeps only the command
    assign ed_ok   = count_reg < CW'(DEPTH);
    assign l_ok    = count_reg < CW'(DEPTH - 1);
    assign push_ed = req.step && req.push_pair && ed_ok;

    always_comb
    begin
        n_push = '0;
        if (req.push_pair && ed_ok)
        begin
            n_push = l_ok ? CW'(2) : CW'(1);
        end
        count_next = count_reg + n_push - CW'(req.pop);
    end

    // Startup fill: command byte at slot 0, LED bits at slot 1
    always_comb
    begin
        case (fill_reg)
            ksd_pkg::FILL_CMD:  fill_next = ksd_pkg::FILL_LEDS;
            ksd_pkg::FILL_LEDS: fill_next = ksd_pkg::FILL_DONE;
            ksd_pkg::FILL_DONE: fill_next = ksd_pkg::FILL_DONE;
            default:            fill_next = ksd_pkg::FILL_DONE;
        endcase
    end

    always_comb
    begin
        fill_we   = 1'b0;
        fill_addr = '0;
        fill_data = ksd_pkg::LED_CMD;
        case (fill_reg)
            ksd_pkg::FILL_CMD:
            begin
                fill_we   = 1'b1;
                fill_addr = AW'(0);
                fill_data = ksd_pkg::LED_CMD;
            end
            ksd_pkg::FILL_LEDS:
            begin
                fill_we   = 1'b1;
                fill_addr = AW'(1);
                fill_data = {{(8-ksd_pkg::LED_W){1'b0}}, restart_leds};
            end
            ksd_pkg::FILL_DONE:
            begin
                fill_we = 1'b0;
            end
            default:
            begin
                fill_we = 1'b0;
            end
        endcase
    end

    // One write port: fill, then the held LED byte, then a new command byte
    always_comb
    begin
        we    = 1'b0;
        waddr = tail;
        wdata = ksd_pkg::LED_CMD;
        if (fill_we)
        begin
            we    = 1'b1;
            waddr = fill_addr;
            wdata = fill_data;
        end
        else if (pend_reg)
        begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = pend_data_reg;
        end
        else if (push_ed)
        begin
            we    = 1'b1;
            waddr = tail;
            wdata = ksd_pkg::LED_CMD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= ksd_pkg::FILL_CMD;
            head_reg   <= '0;
            count_reg  <= CW'(2);
            pend_reg   <= 1'b0;
            settle_reg <= 1'b1;
        end
        else if (restart)
        begin
            fill_reg   <= ksd_pkg::FILL_CMD;
            head_reg   <= '0;
            count_reg  <= CW'(2);
            pend_reg   <= 1'b0;
            settle_reg <= 1'b1;
        end
        else
        begin
            fill_reg   <= fill_next;
            pend_reg   <= push_ed && l_ok;
            settle_reg <= we || (req.step && req.pop);
            if (req.step)
            begin
                count_reg <= count_next;
                if (req.pop)
                begin
                    head_reg <= head_adv;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ed)
        begin
            pend_addr_reg <= tail1;
            pend_data_reg <= {{(8-ksd_pkg::LED_W){1'b0}}, req.leds};
        end
    end

    ksd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (head_reg),
        .rdata (rdata)
    );

    // Read data is trusted only once the registered RAM read has settled after the last write or head move.
    // An empty queue pops the command byte pushed in the same step.
    assign status.ready    = (fill_reg == ksd_pkg::FILL_DONE) && !pend_reg && !settle_reg;
    assign status.empty    = (count_reg == '0);
    assign status.pop_byte = status.empty ? ksd_pkg::LED_CMD : rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/ksd_out_buf.sv
`default_nettype none

module ksd_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          r0_valid,
    input  wire ksd_pkg::res_t r0,
    input  wire logic          r1_valid,
    input  wire ksd_pkg::res_t r1,
    input  wire logic          out_stall,
    output logic               out_valid,
    output ksd_pkg::res_t      out_res,
    output logic               can_load
);

    logic          q0_valid_reg, q1_valid_reg;
    ksd_pkg::res_t q0_reg, q1_reg;
    logic          advance;

    assign advance  = !q0_valid_reg || !out_stall;
    assign can_load = !q1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            q0_valid_reg <= r0_valid;
            q1_valid_reg <= r1_valid;
        end
        else if (advance)
        begin
            q0_valid_reg <= q1_valid_reg;
            q1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q0_reg <= r0;
            q1_reg <= r1;
        end
        else if (advance)
        begin
            q0_reg <= q1_reg;
        end
    end

    assign out_valid = q0_valid_reg;
    assign out_res   = q0_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/keyboard_scancode_decoder.sv
// The taken scancode waits in the input register; its result words then load into the output buffer,
// the second one behind the first. Throughput: one scancode per cycle while the queue read is settled and
// the buffer has room; a byte popped for the keyboard or a lock toggle stalls input, set by the single
// write port and registered read of the queue RAM. Reset clears control state, then loads LED command
// and LED bits into the queue before decoding resumes; a write to initial_leds repeats that sequence.
`default_nettype none
`include "keyboard_scancode_decoder_macros.svh"

module keyboard_scancode_decoder #(
    parameter int QUEUE_DEPTH = ksd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ksd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ksd_pkg::DATA_W-1:0]   pwdata,
    output logic      [ksd_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    // scancode words in
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   scancode,
    // result words out
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              kind,
    output logic      [7:0]                   value,
    output logic                              last
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [ksd_pkg::LED_W-1:0] initial_leds_reg;
    logic                      cfg_sel;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[ksd_pkg::ADDR_W-1:2] == ksd_pkg::REG_INITIAL_LEDS);
    // Write lands on the access phase; only initial_leds exists, other words drop
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

    always_comb
    begin
        prdata = '0;
        if (cfg_sel)
        begin
            prdata = {{(ksd_pkg::DATA_W-ksd_pkg::LED_W){1'b0}}, initial_leds_reg};
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one scancode until the decode step fires
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_code_reg;
    logic       proc;

    assign in_stall = in_valid_reg && !proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_code_reg <= scancode;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    logic [1:0]                shift_bits_reg, shift_bits_next;
    logic [ksd_pkg::LED_W-1:0] lock_bits_reg, lock_bits_next;
    logic                      awaiting_ack_reg, awaiting_ack_next;
    logic [7:0]                in_flight_reg, in_flight_next;

    // ------------------------------------------------------------------
    // Decode: one pass over the registered scancode
    // ------------------------------------------------------------------
    ksd_pkg::q_req_t    q_req;
    ksd_pkg::q_status_t q_st;
    ksd_pkg::res_t      r0, r1;
    logic               r0_valid, r1_valid;
    logic               ob_can_load;

    logic                      shifted, caps, is_letter;
    logic [7:0]                ch_raw, ch;
    logic                      char_v;
    logic                      is_resend, is_ack;
    logic [ksd_pkg::LED_W-1:0] lock_mask;
    logic                      toggle;
    logic                      awaiting_mid;
    logic [7:0]                in_flight_mid;
    logic                      pop;

    assign shifted = (shift_bits_reg != 2'b00);
    assign caps    = lock_bits_reg[ksd_pkg::LOCK_CAPS_BIT];
    assign ch_raw  = shifted ? ksd_pkg::shifted_map(in_code_reg[6:0])
                             : ksd_pkg::plain_map(in_code_reg[6:0]);
    assign is_letter = (ch_raw >= ksd_pkg::LETTER_A) && (ch_raw <= ksd_pkg::LETTER_Z);
    // Lowercase unless exactly one of caps lock and shift is on
    assign ch      = (is_letter && (caps == shifted)) ? ch_raw + ksd_pkg::CASE_OFFSET : ch_raw;
    assign char_v  = !in_code_reg[7] && (ch != 8'h00);

    assign is_ack    = (in_code_reg == ksd_pkg::KB_ACK);
    assign is_resend = (in_code_reg == ksd_pkg::KB_RESEND);

    always_comb
    begin
        shift_bits_next = shift_bits_reg;
        case (in_code_reg)
            ksd_pkg::SC_LSHIFT_MAKE:  shift_bits_next = shift_bits_reg | 2'b01;
            ksd_pkg::SC_RSHIFT_MAKE:  shift_bits_next = shift_bits_reg | 2'b10;
            ksd_pkg::SC_LSHIFT_BREAK: shift_bits_next = shift_bits_reg & 2'b10;
            ksd_pkg::SC_RSHIFT_BREAK: shift_bits_next = shift_bits_reg & 2'b01;
            default:                  shift_bits_next = shift_bits_reg;
        endcase
    end

    always_comb
    begin
        lock_mask = '0;
        case (in_code_reg)
            ksd_pkg::SC_CAPS:   lock_mask = ksd_pkg::MASK_CAPS;
            ksd_pkg::SC_NUM:    lock_mask = ksd_pkg::MASK_NUM;
            ksd_pkg::SC_SCROLL: lock_mask = ksd_pkg::MASK_SCROLL;
            default:            lock_mask = '0;
        endcase
    end

    assign toggle         = (lock_mask != '0);
    assign lock_bits_next = lock_bits_reg ^ lock_mask;

    // Acknowledge frees the link before the pop decision
    assign awaiting_mid  = is_ack ? 1'b0 : awaiting_ack_reg;
    assign in_flight_mid = is_ack ? ksd_pkg::NO_BYTE : in_flight_reg;

    // Send the queue head when something is queued (this step's push counts) and no acknowledge is awaited
    assign pop = (!q_st.empty || toggle) && !awaiting_mid;

    assign awaiting_ack_next = pop ? 1'b1 : awaiting_mid;
    assign in_flight_next    = pop ? q_st.pop_byte : in_flight_mid;

    // Pack results: character or resend first, then the popped byte
    always_comb
    begin
        r0_valid = char_v || is_resend || pop;
        r1_valid = (char_v || is_resend) && pop;

        r1.kind  = ksd_pkg::KIND_CMD;
        r1.value = q_st.pop_byte;
        r1.last  = 1'b1;

        if (char_v)
        begin
            r0.kind  = ksd_pkg::KIND_CHAR;
            r0.value = ch;
        end
        else if (is_resend)
        begin
            r0.kind  = ksd_pkg::KIND_CMD;
            r0.value = in_flight_mid;
        end
        else
        begin
            r0.kind  = ksd_pkg::KIND_CMD;
            r0.value = q_st.pop_byte;
        end
        r0.last = !r1_valid;
    end

    // Fire when a scancode waits, the queue read is settled and the buffer has room
    assign proc = in_valid_reg && q_st.ready && ob_can_load;

    assign q_req.step      = proc;
    assign q_req.push_pair = toggle;
    assign q_req.pop       = pop;
    assign q_req.leds      = lock_bits_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_leds_reg <= '0;
            shift_bits_reg   <= '0;
            lock_bits_reg    <= '0;
            awaiting_ack_reg <= 1'b0;
            in_flight_reg    <= ksd_pkg::NO_BYTE;
        end
        else if (cfg_wr)
        begin
            // Restart the LED sequence; shift state is kept
            initial_leds_reg <= pwdata[ksd_pkg::LED_W-1:0];
            lock_bits_reg    <= pwdata[ksd_pkg::LED_W-1:0];
            awaiting_ack_reg <= 1'b0;
            in_flight_reg    <= ksd_pkg::NO_BYTE;
        end
        else if (proc)
        begin
            shift_bits_reg   <= shift_bits_next;
            lock_bits_reg    <= lock_bits_next;
            awaiting_ack_reg <= awaiting_ack_next;
            in_flight_reg    <= in_flight_next;
        end
    end

    // ------------------------------------------------------------------
    // Command queue and result buffer
    // ------------------------------------------------------------------
    // The LED byte of the startup fill comes from the stored register, which
    // already holds the new value by the time the fill writes it
    ksd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_wr),
        .restart_leds (initial_leds_reg),
        .req          (q_req),
        .status       (q_st)
    );

    ksd_pkg::res_t out_res;

    ksd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc),
        .r0_valid  (r0_valid),
        .r0        (r0),
        .r1_valid  (r1_valid),
        .r1        (r1),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .can_load  (ob_can_load)
    );

    assign kind  = out_res.kind;
    assign value = out_res.value;
    assign last  = out_res.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KSD_ASSERT_NEXT(a_pop_sets_wait, clk, rst_n, proc && pop && !cfg_wr,
        awaiting_ack_reg, "sent byte did not arm the acknowledge wait")

    `KSD_ASSERT_NEXT(a_second_word_follows, clk, rst_n, out_valid && !out_stall && !last,
        out_valid, "second result word of a scancode went missing")

    `KSD_ASSERT_NEXT(a_held_code_kept, clk, rst_n, in_valid_reg && !proc,
        in_valid_reg, "undecoded scancode dropped from the input register")

endmodule

`default_nettype wire
